// File: rtl/core/cipc_pkg.sv
// Package for the cascaded interrupt priority controller core.
// Holds opcodes, register indexes, widths, shared types and the priority encoder.
// Has no dependencies.
package cipc_pkg;

    localparam int MASK_W = 8;
    localparam int LINE_W = 4;
    localparam int VECTOR_W = 6;
    localparam int CFG_INDEX_W = 1;

    localparam logic [VECTOR_W-1:0] VECTOR_BASE = 6'd32;
    localparam logic [2:0] CASCADE_BIT = 3'd2;
    localparam logic [LINE_W-1:0] NO_LINE = 4'd8;

    typedef enum logic
    {
        OP_RAISE = 1'b0,
        OP_ACK   = 1'b1
    } opcode_t;

    typedef enum logic [CFG_INDEX_W-1:0]
    {
        REG_MASTER_MASK = 1'b0,
        REG_SLAVE_MASK  = 1'b1
    } cfg_index_t;

    typedef struct packed
    {
        logic              req;
        logic [LINE_W-1:0] line;
    } resolve_t;

    // Returns the index of the lowest set bit, or eight when no bit is set.
    function automatic logic [LINE_W-1:0] lowest_set(input logic [MASK_W-1:0] v);
        logic [LINE_W-1:0] idx;
        idx = NO_LINE;
        for (int i = MASK_W - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = i[LINE_W-1:0];
            end
        end
        return idx;
    endfunction

endpackage

// File: rtl/core/cipc_if.sv
// Handshake interfaces for the request and result channels.
// Depends on cipc_pkg for field widths.
interface cipc_req_if;
    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic [cipc_pkg::LINE_W-1:0]   line;

    modport source (output valid, output opcode, output line, input ready);
    modport sink (input valid, input opcode, input line, output ready);
endinterface

interface cipc_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          intr_request;
    logic [cipc_pkg::VECTOR_W-1:0] vector;

    modport source (output valid, output intr_request, output vector, input ready);
    modport sink (input valid, input intr_request, input vector, output ready);
endinterface

// File: rtl/core/cascaded_interrupt_priority_controller_core.sv
// Top level of the cascaded interrupt priority controller core.
// Depends on cipc_pkg, the interfaces in cipc_if and cipc_resolve.

// A master/slave pair of 8-line priority controllers behind a single request channel.
// The block takes one request per clock cycle unless result.ready holds back the result, and returns
// one result for each: an accepted request waits in the input register, and when it advances the
// request bits are updated, the winner is resolved by two 8-bit priority encoders and the
// result register is loaded.
// The request-bit update and the encoders form the single feedback path that sets this rate.
// The mask registers may be written only while no request is in flight.
module cascaded_interrupt_priority_controller_core
(
    input  logic                             clk,
    input  logic                             rst_n,
    cipc_req_if.sink                         request,
    cipc_rsp_if.source                       result,
    input  logic                             cfg_wr_en,
    input  logic [cipc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [cipc_pkg::MASK_W-1:0]      cfg_data
);

    logic                          s1_valid_reg;
    logic                          s1_opcode_reg;
    logic [cipc_pkg::LINE_W-1:0]   s1_line_reg;

    logic [cipc_pkg::MASK_W-1:0]   master_mask_reg;
    logic [cipc_pkg::MASK_W-1:0]   slave_mask_reg;
    logic [cipc_pkg::MASK_W-1:0]   master_req_reg;
    logic [cipc_pkg::MASK_W-1:0]   slave_req_reg;
    logic [cipc_pkg::LINE_W-1:0]   cur_line_reg;
    logic                          cur_valid_reg;

    logic                          out_valid_reg;
    logic                          out_intr_reg;
    logic [cipc_pkg::VECTOR_W-1:0] out_vector_reg;

    logic [cipc_pkg::MASK_W-1:0]   master_req_next;
    logic [cipc_pkg::MASK_W-1:0]   slave_req_next;
    logic                          advance;
    logic                          take;
    cipc_pkg::resolve_t            winner;

    assign advance = s1_valid_reg && (!out_valid_reg || result.ready);
    assign request.ready = !s1_valid_reg || advance;
    assign take = request.valid && request.ready;

    // A slave line always involves the master's cascade bit, on raise and on acknowledge.
    always_comb
    begin
        master_req_next = master_req_reg;
        slave_req_next  = slave_req_reg;
        if (s1_opcode_reg == cipc_pkg::OP_RAISE)
        begin
            if (!s1_line_reg[3])
            begin
                master_req_next[s1_line_reg[2:0]] = 1'b1;
            end
            else
            begin
                slave_req_next[s1_line_reg[2:0]]     = 1'b1;
                master_req_next[cipc_pkg::CASCADE_BIT] = 1'b1;
            end
        end
        else if (cur_valid_reg)
        begin
            if (!cur_line_reg[3])
            begin
                master_req_next[cur_line_reg[2:0]] = 1'b0;
            end
            else
            begin
                slave_req_next[cur_line_reg[2:0]]    = 1'b0;
                master_req_next[cipc_pkg::CASCADE_BIT] = 1'b0;
            end
        end
    end

    cipc_resolve u_resolve
    (
        .master_requests (master_req_next),
        .slave_requests  (slave_req_next),
        .master_mask     (master_mask_reg),
        .slave_mask      (slave_mask_reg),
        .winner          (winner)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            master_mask_reg <= '0;
            slave_mask_reg  <= '0;
            master_req_reg  <= '0;
            slave_req_reg   <= '0;
            cur_line_reg    <= '0;
            cur_valid_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    cipc_pkg::REG_MASTER_MASK: master_mask_reg <= cfg_data;
                    cipc_pkg::REG_SLAVE_MASK:  slave_mask_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (request.ready)
            begin
                s1_valid_reg <= request.valid;
            end
            if (advance)
            begin
                master_req_reg <= master_req_next;
                slave_req_reg  <= slave_req_next;
                cur_line_reg   <= winner.line;
                cur_valid_reg  <= winner.req;
                out_valid_reg  <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_opcode_reg <= request.opcode;
            s1_line_reg   <= request.line;
        end
        if (advance)
        begin
            out_intr_reg   <= winner.req;
            out_vector_reg <= winner.req
                ? cipc_pkg::VECTOR_BASE + {2'b00, winner.line}
                : '0;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.intr_request = out_intr_reg;
    assign result.vector       = out_vector_reg;

endmodule

// File: rtl/core/cipc_resolve.sv
// Priority resolution across the master and slave request bits.
// Depends on cipc_pkg for the encoder, the cascade bit and the result type.
module cipc_resolve
(
    input  logic [cipc_pkg::MASK_W-1:0] master_requests,
    input  logic [cipc_pkg::MASK_W-1:0] slave_requests,
    input  logic [cipc_pkg::MASK_W-1:0] master_mask,
    input  logic [cipc_pkg::MASK_W-1:0] slave_mask,
    output cipc_pkg::resolve_t          winner
);

    logic [cipc_pkg::LINE_W-1:0] mwin;
    logic [cipc_pkg::LINE_W-1:0] swin;

    assign mwin = cipc_pkg::lowest_set(master_requests & ~master_mask);
    assign swin = cipc_pkg::lowest_set(slave_requests & ~slave_mask);

    // A winning cascade bit hands the decision to the slave; an empty slave means no request.
    always_comb
    begin
        winner.req  = 1'b0;
        winner.line = '0;
        if (!mwin[3])
        begin
            if (mwin[2:0] == cipc_pkg::CASCADE_BIT)
            begin
                if (!swin[3])
                begin
                    winner.req  = 1'b1;
                    winner.line = {1'b1, swin[2:0]};
                end
            end
            else
            begin
                winner.req  = 1'b1;
                winner.line = mwin;
            end
        end
    end

endmodule
